@@ rtl/core/arpm_pkg.sv @@
// Shared types, constants and helper functions of the record/playback meter.
// Depends on nothing; imported by audio_record_playback_meter.
`default_nettype none

package arpm_pkg;

	// Storage and meter geometry.
	localparam int MEMORY_DEPTH   = 262144;
	localparam int BAR_TOTAL      = 12;
	localparam int BAR_MAX_HEIGHT = 64;

	// Field widths.
	localparam int ADDR_W   = $clog2(MEMORY_DEPTH);
	localparam int IDX_W    = 19;
	localparam int SAMPLE_W = 8;
	localparam int ADC_W    = 12;
	localparam int BAR_W    = 4;
	localparam int HEIGHT_W = 6;
	localparam int CFG_W    = 19;
	localparam int CFG_IDX_W = 2;

	// Register reset values.
	localparam logic [IDX_W-1:0]    RECORD_LENGTH_RST = IDX_W'(160000);
	localparam logic [SAMPLE_W-1:0] DUTY_FLOOR_RST    = SAMPLE_W'(30);
	localparam logic [SAMPLE_W-1:0] DUTY_CEILING_RST  = SAMPLE_W'(220);

	// Largest length the memory can hold, as an index value.
	localparam logic [IDX_W-1:0] DEPTH_IDX = IDX_W'(MEMORY_DEPTH);
	localparam logic [BAR_W-1:0] BAR_LAST  = BAR_W'(BAR_TOTAL - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_RECORD_LENGTH = 2'd0,
		REG_DUTY_FLOOR    = 2'd1,
		REG_DUTY_CEILING  = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		ACT_RECORD      = 2'd0,
		ACT_PLAY        = 2'd1,
		ACT_START_REC   = 2'd2,
		ACT_START_PLAY  = 2'd3
	} action_t;

	// What the first stage decided for an item.
	typedef enum logic [1:0] {
		KIND_ZERO = 2'd0,
		KIND_REC  = 2'd1,
		KIND_PLAY = 2'd2,
		KIND_DONE = 2'd3
	} kind_t;

	// Meter height (BAR_MAX_HEIGHT-1)*v/255, masked to the field width.
	// Division by 255 uses (x + 1 + (x >> 8)) >> 8, exact for x below 65535.
	function automatic logic [HEIGHT_W-1:0] bar_height_f(input logic [SAMPLE_W-1:0] v);
		logic [16:0] x;
		logic [16:0] q;
		x = 17'(v) * 17'(BAR_MAX_HEIGHT - 1);
		q = (x + 17'd1 + (x >> 8)) >> 8;
		return q[HEIGHT_W-1:0];
	endfunction

	// Floor first, then ceiling, so the ceiling wins when they cross.
	function automatic logic [SAMPLE_W-1:0] clamp_f(input logic [SAMPLE_W-1:0] v,
			input logic [SAMPLE_W-1:0] lo, input logic [SAMPLE_W-1:0] hi);
		logic [SAMPLE_W-1:0] d;
		d = (v < lo) ? lo : v;
		d = (d > hi) ? hi : d;
		return d;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/audio_record_playback_meter.sv @@
// Top level of the audio record/playback engine with level meter.
// Depends on arpm_pkg; holds the sample memory and the two-stage pipeline.
`default_nettype none

// The block takes one item per clock cycle on the input stream while the output
// is not stalled, and returns exactly one result item for each. Of its stages, the
// first stage decides record, play, start or done against the write or read
// index and issues the single access to the sample memory (a write for a
// record tick, a registered read for a play tick); the second stage takes the
// read data, clamps it to the duty range, forms the meter height and loads
// the output register. Without an output stall, throughput is one item per cycle, set by
// the one port of the sample memory, which every tick uses at most once. The output
// register lets a new item enter while a finished result still waits. The
// memory needs no clearing after reset; reading a never-written entry gives
// an arbitrary sample. Configuration writes are meant for idle periods.
module audio_record_playback_meter
	import arpm_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // [11:0] adc_sample
	input  wire logic [1:0]  s_tuser,   // [1:0] action
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] sample_value, [15:8] pwm_level, [19:16] bar_index, [25:20] bar_height
	output logic [31:0]      m_tdata,
	output logic             m_tuser,   // [0] done_res
	output logic             m_tlast,   // last bar of a frame
	input  wire logic        cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	// Configuration registers.
	logic [IDX_W-1:0]    record_length_q;
	logic [SAMPLE_W-1:0] duty_floor_q;
	logic [SAMPLE_W-1:0] duty_ceiling_q;

	// Indices and their running position modulo the bar count.
	logic [IDX_W-1:0] write_index_q;
	logic [IDX_W-1:0] read_index_q;
	logic [BAR_W-1:0] write_bar_q;
	logic [BAR_W-1:0] read_bar_q;

	// Sample memory, single port, registered read.
	logic [SAMPLE_W-1:0] sample_mem [MEMORY_DEPTH];
	logic [SAMPLE_W-1:0] rd_data_s1;

	// Stage one.
	logic                valid_s1;
	kind_t               kind_s1;
	logic [SAMPLE_W-1:0] value_s1;
	logic [BAR_W-1:0]    bar_s1;

	// Output register.
	logic                valid_s2;
	logic [SAMPLE_W-1:0] value_s2;
	logic [SAMPLE_W-1:0] pwm_s2;
	logic [BAR_W-1:0]    bar_s2;
	logic [HEIGHT_W-1:0] height_s2;
	logic                frame_s2;
	logic                done_s2;

	logic                accept;
	logic                advance;
	action_t             action;
	logic [IDX_W-1:0]    limit;
	logic                rec_full;
	logic                play_empty;
	logic [BAR_W-1:0]    write_bar_nxt;
	logic [BAR_W-1:0]    read_bar_nxt;
	logic [SAMPLE_W-1:0] adc_cut;
	logic                mem_we;
	logic                mem_re;
	logic [ADDR_W-1:0]   mem_addr;
	kind_t               kind_nxt;
	logic [BAR_W-1:0]    bar_nxt;

	logic [SAMPLE_W-1:0] fin_value;
	logic [SAMPLE_W-1:0] fin_pwm;
	logic [HEIGHT_W-1:0] fin_height;
	logic                fin_frame;
	logic                fin_done;
	logic [BAR_W-1:0]    fin_bar;

	// Handshake: stage one moves on when the output register is free or drains.
	assign advance  = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || advance;
	assign accept   = s_tvalid && s_tready;

	assign action  = action_t'(s_tuser);
	assign adc_cut = s_tdata[ADC_W-1:ADC_W-SAMPLE_W];

	// Effective length is the record length saturated to the memory depth.
	assign limit      = (record_length_q > DEPTH_IDX) ? DEPTH_IDX : record_length_q;
	assign rec_full   = (write_index_q >= limit);
	assign play_empty = (read_index_q >= limit);

	assign write_bar_nxt = (write_bar_q == BAR_LAST) ? '0 : write_bar_q + BAR_W'(1);
	assign read_bar_nxt  = (read_bar_q == BAR_LAST) ? '0 : read_bar_q + BAR_W'(1);

	always_comb begin
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_addr = write_index_q[ADDR_W-1:0];
		kind_nxt = KIND_ZERO;
		bar_nxt  = '0;
		unique case (action)
			ACT_RECORD: begin
				if (rec_full) begin
					kind_nxt = KIND_DONE;
				end else begin
					kind_nxt = KIND_REC;
					mem_we   = accept;
					bar_nxt  = write_bar_nxt;
				end
			end
			ACT_PLAY: begin
				mem_addr = read_index_q[ADDR_W-1:0];
				if (play_empty) begin
					kind_nxt = KIND_DONE;
				end else begin
					kind_nxt = KIND_PLAY;
					mem_re   = accept;
					bar_nxt  = read_bar_nxt;
				end
			end
			// Both start actions give an all-zero result.
			default: begin
				kind_nxt = KIND_ZERO;
			end
		endcase
	end

	// Sample memory port. A play tick right after a record tick to the same
	// entry reads in the next cycle, so it already sees the new sample.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			sample_mem[mem_addr] <= adc_cut;
		end
		if (mem_re) begin
			rd_data_s1 <= sample_mem[mem_addr];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			record_length_q <= RECORD_LENGTH_RST;
			duty_floor_q    <= DUTY_FLOOR_RST;
			duty_ceiling_q  <= DUTY_CEILING_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RECORD_LENGTH: record_length_q <= cfg_data;
				REG_DUTY_FLOOR:    duty_floor_q    <= cfg_data[SAMPLE_W-1:0];
				REG_DUTY_CEILING:  duty_ceiling_q  <= cfg_data[SAMPLE_W-1:0];
				default: ;
			endcase
		end
	end

	// Index and bar position updates on accepted items.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_index_q <= '0;
			read_index_q  <= '0;
			write_bar_q   <= '0;
			read_bar_q    <= '0;
		end else if (accept) begin
			unique case (action)
				ACT_RECORD: begin
					if (!rec_full) begin
						write_index_q <= write_index_q + IDX_W'(1);
						write_bar_q   <= write_bar_nxt;
					end
				end
				ACT_PLAY: begin
					if (!play_empty) begin
						read_index_q <= read_index_q + IDX_W'(1);
						read_bar_q   <= read_bar_nxt;
					end
				end
				ACT_START_REC: begin
					write_index_q <= '0;
					write_bar_q   <= '0;
				end
				ACT_START_PLAY: begin
					read_index_q <= '0;
					read_bar_q   <= '0;
				end
				default: ;
			endcase
		end
	end

	// Stage one registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			kind_s1  <= KIND_ZERO;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
			if (s_tvalid) begin
				kind_s1 <= kind_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= adc_cut;
			bar_s1   <= bar_nxt;
		end
	end

	// Stage two: pick the sample, clamp it, and form the meter fields.
	always_comb begin
		fin_value  = '0;
		fin_pwm    = '0;
		fin_bar    = '0;
		fin_height = '0;
		fin_frame  = 1'b0;
		fin_done   = 1'b0;
		unique case (kind_s1)
			KIND_REC: begin
				fin_value  = value_s1;
				fin_bar    = bar_s1;
				fin_height = bar_height_f(value_s1);
				fin_frame  = (bar_s1 == BAR_LAST);
			end
			KIND_PLAY: begin
				fin_value  = rd_data_s1;
				fin_pwm    = clamp_f(rd_data_s1, duty_floor_q, duty_ceiling_q);
				fin_bar    = bar_s1;
				fin_height = bar_height_f(rd_data_s1);
				fin_frame  = (bar_s1 == BAR_LAST);
			end
			KIND_DONE: begin
				fin_done = 1'b1;
			end
			KIND_ZERO: begin
				fin_done = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			value_s2  <= fin_value;
			pwm_s2    <= fin_pwm;
			bar_s2    <= fin_bar;
			height_s2 <= fin_height;
			frame_s2  <= fin_frame;
			done_s2   <= fin_done;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, height_s2, bar_s2, pwm_s2, value_s2};
	assign m_tuser  = done_s2;
	assign m_tlast  = frame_s2;

	// A done result carries no sample and closes no frame.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> (m_tdata == 32'd0) && !m_tlast)
		else $error("done result with nonzero payload");

	// A frame closes only on the last bar.
	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> (m_tdata[19:16] == BAR_LAST))
		else $error("frame end flag on a bar other than the last");

	// Indices never run past the memory, and bar positions stay in range.
	assert property (@(posedge clk) disable iff (!arst_n)
		(write_index_q <= DEPTH_IDX) && (read_index_q <= DEPTH_IDX)
		&& (write_bar_q <= BAR_LAST) && (read_bar_q <= BAR_LAST))
		else $error("index or bar position out of range");

	// A memory write is only issued for an accepted record tick below the limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> (write_index_q == $past(write_index_q) + IDX_W'(1)))
		else $error("memory written without advancing the write index");

endmodule

`default_nettype wire
